@@ src/fpsd_pkg.sv @@
// fpsd_pkg: shared types and constants of the four-position switch debouncer
// register map, reset values, configuration and state structs
// no dependencies

package fpsd_pkg;

  // configuration register index, byte address is 4 times the index
  typedef enum logic [2:0] {
    REG_P0P1_LOW  = 3'd0,
    REG_P0P1_HIGH = 3'd1,
    REG_P1P2_LOW  = 3'd2,
    REG_P1P2_HIGH = 3'd3,
    REG_P2P3_LOW  = 3'd4,
    REG_P2P3_HIGH = 3'd5,
    REG_DEBOUNCE  = 3'd6
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned POS_W  = 2;
  localparam int unsigned NUM_CLASSES = 4;

  // reset values of the thresholds and the debounce time
  localparam logic [VOLT_W-1:0] RST_P0P1_LOW  = 16'd500;
  localparam logic [VOLT_W-1:0] RST_P0P1_HIGH = 16'd600;
  localparam logic [VOLT_W-1:0] RST_P1P2_LOW  = 16'd1600;
  localparam logic [VOLT_W-1:0] RST_P1P2_HIGH = 16'd1700;
  localparam logic [VOLT_W-1:0] RST_P2P3_LOW  = 16'd2700;
  localparam logic [VOLT_W-1:0] RST_P2P3_HIGH = 16'd2800;
  localparam logic [VOLT_W-1:0] RST_DEBOUNCE  = 16'd50;

  typedef struct packed {
    logic [VOLT_W-1:0] p0p1_low;
    logic [VOLT_W-1:0] p0p1_high;
    logic [VOLT_W-1:0] p1p2_low;
    logic [VOLT_W-1:0] p1p2_high;
    logic [VOLT_W-1:0] p2p3_low;
    logic [VOLT_W-1:0] p2p3_high;
    logic [VOLT_W-1:0] debounce_ms;
  } cfg_t;

  // debouncer state: confirming flag, candidate, confirmed position, start time
  typedef struct packed {
    logic              confirming;
    logic [POS_W-1:0]  target;
    logic [POS_W-1:0]  confirmed;
    logic [TIME_W-1:0] start_time;
  } state_t;

endpackage

@@ src/fpsd_step.sv @@
// fpsd_step: classification of one sample and next-state logic of the debouncer
// purely combinational; uses fpsd_pkg for the cfg_t and state_t structs

module fpsd_step (
  input  fpsd_pkg::cfg_t                    cfg,
  input  fpsd_pkg::state_t                  state,
  input  logic [fpsd_pkg::VOLT_W-1:0]       voltage,
  input  logic [fpsd_pkg::TIME_W-1:0]       now_ms,
  output fpsd_pkg::state_t                  state_nxt
);

  logic [fpsd_pkg::NUM_CLASSES-1:0] class_mask;
  logic [fpsd_pkg::NUM_CLASSES-1:0] conf_bit;
  logic [fpsd_pkg::NUM_CLASSES-1:0] targ_bit;
  logic [fpsd_pkg::NUM_CLASSES-1:0] others;
  logic [fpsd_pkg::POS_W-1:0]       lowest_other;
  logic [fpsd_pkg::TIME_W-1:0]      limit;
  logic                             expired;

  // class membership, gaps give an empty mask
  always_comb begin
    class_mask[0] = voltage < cfg.p0p1_low;
    class_mask[1] = (voltage > cfg.p0p1_high) && (voltage < cfg.p1p2_low);
    class_mask[2] = (voltage > cfg.p1p2_high) && (voltage < cfg.p2p3_low);
    class_mask[3] = voltage > cfg.p2p3_high;
  end

  assign conf_bit = fpsd_pkg::NUM_CLASSES'(1) << state.confirmed;
  assign targ_bit = fpsd_pkg::NUM_CLASSES'(1) << state.target;

  // classes that may start or restart confirmation
  always_comb begin
    if (state.confirming) begin
      others = class_mask & ~conf_bit & ~targ_bit;
    end else begin
      others = class_mask & ~targ_bit;
    end
  end

  // lowest set class of the other mask
  always_comb begin
    priority if (others[0]) begin
      lowest_other = 2'd0;
    end else if (others[1]) begin
      lowest_other = 2'd1;
    end else if (others[2]) begin
      lowest_other = 2'd2;
    end else begin
      lowest_other = 2'd3;
    end
  end

  // debounce deadline wraps modulo 2^32
  assign limit   = state.start_time + {{(fpsd_pkg::TIME_W-fpsd_pkg::VOLT_W){1'b0}},
                                       cfg.debounce_ms};
  assign expired = now_ms > limit;

  always_comb begin
    state_nxt = state;
    if (!state.confirming) begin
      // stable: confirmed position follows the settled candidate
      state_nxt.confirmed = state.target;
      if (others != '0) begin
        state_nxt.confirming = 1'b1;
        state_nxt.target     = lowest_other;
        state_nxt.start_time = now_ms;
      end
    end else begin
      priority if ((class_mask & conf_bit) != '0) begin
        // back to the confirmed position
        state_nxt.confirming = 1'b0;
        state_nxt.target     = state.confirmed;
      end else if (others != '0) begin
        // a third class restarts confirmation
        state_nxt.target     = lowest_other;
        state_nxt.start_time = now_ms;
      end else if (((class_mask & targ_bit) != '0) && expired) begin
        state_nxt.confirming = 1'b0;
      end
    end
  end

endmodule

@@ src/four_position_switch_debouncer.sv @@
// four_position_switch_debouncer: top level with APB register file and handshakes
// depends on fpsd_pkg and fpsd_step

// Takes one voltage sample with a millisecond time stamp per transfer and returns
// one result per sample: the confirmed position, the confirming flag and the
// candidate position, all after that sample's update. Throughput is one sample
// per clock while the result channel does not stall; a sample waits in the input
// register, then the class compares and the deadline add update the state as it
// moves into the result register, which drives the output.
// While a result waits at the output, the input register still takes one more
// sample. Thresholds and the debounce time sit in APB registers at byte
// addresses 0x00 to 0x18; write them only while no sample is in flight.

module four_position_switch_debouncer (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fpsd_pkg::VOLT_W-1:0]       in_voltage,
  input  logic [fpsd_pkg::TIME_W-1:0]       in_now_ms,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fpsd_pkg::POS_W-1:0]        out_position,
  output logic                              out_confirming,
  output logic [fpsd_pkg::POS_W-1:0]        out_candidate,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpsd_pkg::ADDR_W-1:0]       paddr,
  input  logic [fpsd_pkg::DATA_W-1:0]       pwdata,
  output logic [fpsd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  fpsd_pkg::cfg_t              cfg_r;
  fpsd_pkg::state_t            state_r;
  fpsd_pkg::state_t            state_nxt;
  fpsd_pkg::reg_idx_t          reg_idx;
  logic                        cfg_wr;
  logic [fpsd_pkg::VOLT_W-1:0] rd_val;

  logic                        in_valid_r;
  logic [fpsd_pkg::VOLT_W-1:0] in_voltage_r;
  logic [fpsd_pkg::TIME_W-1:0] in_now_ms_r;
  logic                        out_valid_r;
  logic [fpsd_pkg::POS_W-1:0]  out_position_r;
  logic                        out_confirming_r;
  logic [fpsd_pkg::POS_W-1:0]  out_candidate_r;

  logic                        out_free;
  logic                        step_go;
  logic                        in_take;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = fpsd_pkg::reg_idx_t'(paddr[fpsd_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p0p1_low    <= fpsd_pkg::RST_P0P1_LOW;
      cfg_r.p0p1_high   <= fpsd_pkg::RST_P0P1_HIGH;
      cfg_r.p1p2_low    <= fpsd_pkg::RST_P1P2_LOW;
      cfg_r.p1p2_high   <= fpsd_pkg::RST_P1P2_HIGH;
      cfg_r.p2p3_low    <= fpsd_pkg::RST_P2P3_LOW;
      cfg_r.p2p3_high   <= fpsd_pkg::RST_P2P3_HIGH;
      cfg_r.debounce_ms <= fpsd_pkg::RST_DEBOUNCE;
    end else if (cfg_wr) begin
      case (reg_idx)
        fpsd_pkg::REG_P0P1_LOW:  cfg_r.p0p1_low    <= pwdata[fpsd_pkg::VOLT_W-1:0];
        fpsd_pkg::REG_P0P1_HIGH: cfg_r.p0p1_high   <= pwdata[fpsd_pkg::VOLT_W-1:0];
        fpsd_pkg::REG_P1P2_LOW:  cfg_r.p1p2_low    <= pwdata[fpsd_pkg::VOLT_W-1:0];
        fpsd_pkg::REG_P1P2_HIGH: cfg_r.p1p2_high   <= pwdata[fpsd_pkg::VOLT_W-1:0];
        fpsd_pkg::REG_P2P3_LOW:  cfg_r.p2p3_low    <= pwdata[fpsd_pkg::VOLT_W-1:0];
        fpsd_pkg::REG_P2P3_HIGH: cfg_r.p2p3_high   <= pwdata[fpsd_pkg::VOLT_W-1:0];
        fpsd_pkg::REG_DEBOUNCE:  cfg_r.debounce_ms <= pwdata[fpsd_pkg::VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, unmapped addresses read zero
  always_comb begin
    case (reg_idx)
      fpsd_pkg::REG_P0P1_LOW:  rd_val = cfg_r.p0p1_low;
      fpsd_pkg::REG_P0P1_HIGH: rd_val = cfg_r.p0p1_high;
      fpsd_pkg::REG_P1P2_LOW:  rd_val = cfg_r.p1p2_low;
      fpsd_pkg::REG_P1P2_HIGH: rd_val = cfg_r.p1p2_high;
      fpsd_pkg::REG_P2P3_LOW:  rd_val = cfg_r.p2p3_low;
      fpsd_pkg::REG_P2P3_HIGH: rd_val = cfg_r.p2p3_high;
      fpsd_pkg::REG_DEBOUNCE:  rd_val = cfg_r.debounce_ms;
      default:                 rd_val = '0;
    endcase
  end

  assign prdata = {{(fpsd_pkg::DATA_W-fpsd_pkg::VOLT_W){1'b0}}, rd_val};

  // flow control between input and result registers
  assign out_free = !out_valid_r || !out_stall;
  assign step_go  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_voltage_r <= in_voltage;
      in_now_ms_r  <= in_now_ms;
    end
  end

  // state update
  fpsd_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .voltage   (in_voltage_r),
    .now_ms    (in_now_ms_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_position_r   <= state_nxt.confirmed;
      out_confirming_r <= state_nxt.confirming;
      out_candidate_r  <= state_nxt.target;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_position_r;
  assign out_confirming = out_confirming_r;
  assign out_candidate  = out_candidate_r;

  // a pending candidate always differs from the confirmed position
  a_cand_differs : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.confirming |-> (state_r.target != state_r.confirmed))
    else $error("candidate equals confirmed position while confirming");

  // state only moves when a sample passes into the result register
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !step_go |=> $stable(state_r))
    else $error("state changed without a sample transfer");

  // confirmed position is only loaded from a stable state
  a_confirm_load : assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && state_r.confirming) |=> $stable(state_r.confirmed))
    else $error("confirmed position changed while confirming");

  // no result is dropped while the sink stalls
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !step_go)
    else $error("result register overwritten while stalled");

endmodule
